### sv/itr_pkg.sv
// ----------------------------------------------------------------------------
// itr_pkg
// shared constants and types for the infix to rpn evaluator
// ----------------------------------------------------------------------------
package itr_pkg;
  localparam int StackDepth = 32;
  localparam int ValueWidth = 32;
  localparam int PtrWidth = $clog2(StackDepth + 1);
  localparam int AddrWidth = $clog2(StackDepth);
  localparam int CntWidth = $clog2(ValueWidth + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER = 2'd3;

  localparam logic [7:0] CH_ADD = 8'h2b;
  localparam logic [7:0] CH_SUB = 8'h2d;
  localparam logic [7:0] CH_MUL = 8'h2a;
  localparam logic [7:0] CH_DIV = 8'h2f;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef struct packed {
    logic load;      // capture input item
    logic op_read;   // read operator stack top
    logic val_read;  // read value b (top-1) and a (top-2), two steps
    logic val_read_a;
    logic exec;      // compute a op b (non div)
    logic div_start;
    logic div_step;
    logic wr_result;
    logic push_val;
    logic push_op;
    logic pop_op;
    logic set_out_sym;
    logic set_out_fin;
    logic clear;
    logic [1:0] flag;
  } itr_cmd_t;

  typedef struct packed {
    logic is_letter;
    logic is_op;
    logic is_close;
    logic last;
    logic op_empty;
    logic op_full;
    logic val_full;
    logic val_lt2;
    logic val_empty;
    logic cur_div;
    logic div_zero;
    logic div_done;
  } itr_stat_t;

  function automatic logic [7:0] op_char(input logic [1:0] op);
    case (op)
      OP_ADD: op_char = CH_ADD;
      OP_SUB: op_char = CH_SUB;
      OP_MUL: op_char = CH_MUL;
      default: op_char = CH_DIV;
    endcase
  endfunction
endpackage

### sv/itr_datapath.sv
// ----------------------------------------------------------------------------
// itr_datapath
// stacks, alu, iterative divider and output register
// ----------------------------------------------------------------------------
module itr_datapath (
  input  logic clk,
  input  logic rst,
  input  itr_pkg::itr_cmd_t cmd,
  output itr_pkg::itr_stat_t stat,
  input  logic [7:0] char_code,
  input  logic signed [31:0] operand_value,
  input  logic last,
  output logic [7:0] rpn_char,
  output logic is_final,
  output logic signed [31:0] result_value,
  output logic [1:0] status
);
  import itr_pkg::*;

  logic [1:0] op_mem [StackDepth];
  logic [ValueWidth-1:0] val_mem [StackDepth];
  logic [PtrWidth-1:0] op_top, val_top;
  logic [1:0] sticky;
  logic [7:0] ch;
  logic [ValueWidth-1:0] opv, a, b, rd, res;
  logic [1:0] op, op_rd;
  logic lst;
  logic [ValueWidth-1:0] rem, quo, dvs;
  logic [CntWidth-1:0] cnt;
  logic neg_q;
  logic [ValueWidth:0] trial;
  logic [ValueWidth-1:0] ma, mb;
  logic [AddrWidth-1:0] rd_addr;
  logic [PtrWidth-1:0] vt1, vt2, ot1;

  assign vt1 = val_top - PtrWidth'(1);
  assign vt2 = val_top - PtrWidth'(2);
  assign ot1 = op_top - PtrWidth'(1);
  assign rd_addr = cmd.val_read_a ? vt2[AddrWidth-1:0] : vt1[AddrWidth-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push_op) op_mem[op_top[AddrWidth-1:0]] <= ch == CH_ADD ? OP_ADD :
        ch == CH_SUB ? OP_SUB : ch == CH_MUL ? OP_MUL : OP_DIV;
    op_rd <= op_mem[ot1[AddrWidth-1:0]];
    if (cmd.push_val) val_mem[val_top[AddrWidth-1:0]] <= opv;
    else if (cmd.wr_result) val_mem[vt2[AddrWidth-1:0]] <= res;
    rd <= val_mem[rd_addr];
  end

  assign ma = a[ValueWidth-1] ? -a : a;
  assign mb = b[ValueWidth-1] ? -b : b;
  assign trial = {rem, quo[ValueWidth-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      op_top <= '0;
      val_top <= '0;
      sticky <= ST_OK;
    end else begin
      if (cmd.flag != ST_OK && sticky == ST_OK) sticky <= cmd.flag;
      if (cmd.push_op) op_top <= op_top + PtrWidth'(1);
      if (cmd.pop_op) op_top <= op_top - PtrWidth'(1);
      if (cmd.push_val) val_top <= val_top + PtrWidth'(1);
      if (cmd.wr_result) val_top <= vt1;
      if (cmd.clear) begin
        op_top <= '0;
        val_top <= '0;
        sticky <= ST_OK;
      end
    end
    if (cmd.load) begin
      ch <= char_code;
      opv <= operand_value;
      lst <= last;
    end
    if (cmd.op_read) op <= op_rd;
    if (cmd.val_read) b <= rd;
    if (cmd.val_read_a) a <= rd;
    if (cmd.exec) begin
      case (op)
        OP_ADD: res <= a + b;
        OP_SUB: res <= a - b;
        OP_MUL: res <= a * b;
        default: res <= '0;
      endcase
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= ma;
      dvs <= mb;
      cnt <= CntWidth'(ValueWidth);
      neg_q <= a[ValueWidth-1] ^ b[ValueWidth-1];
    end else if (cmd.div_step) begin
      if (cnt != '0) begin
        if (!trial[ValueWidth]) rem <= trial[ValueWidth-1:0];
        else rem <= {rem[ValueWidth-2:0], quo[ValueWidth-1]};
        quo <= {quo[ValueWidth-2:0], ~trial[ValueWidth]};
        cnt <= cnt - CntWidth'(1);
      end else res <= stat.div_zero ? '0 : (neg_q ? -quo : quo);
    end
    if (cmd.set_out_sym) begin
      rpn_char <= stat.is_letter ? ch : op_char(op);
      is_final <= 1'b0;
      result_value <= '0;
      status <= (cmd.flag != ST_OK && sticky == ST_OK) ? cmd.flag : sticky;
    end else if (cmd.set_out_fin) begin
      rpn_char <= '0;
      is_final <= 1'b1;
      result_value <= stat.val_empty ? '0 : rd;
      status <= (cmd.flag != ST_OK && sticky == ST_OK) ? cmd.flag : sticky;
    end
  end

  always_comb begin
    stat.is_letter = (ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a);
    stat.is_op = ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV;
    stat.is_close = ch == CH_CLOSE;
    stat.last = lst;
    stat.op_empty = op_top == '0;
    stat.op_full = op_top >= PtrWidth'(StackDepth);
    stat.val_full = val_top >= PtrWidth'(StackDepth);
    stat.val_lt2 = val_top < PtrWidth'(2);
    stat.val_empty = val_top == '0;
    stat.cur_div = op == OP_DIV;
    stat.div_zero = dvs == '0;
    stat.div_done = cnt == '0;
  end
endmodule

### sv/itr_ctrl.sv
// ----------------------------------------------------------------------------
// itr_ctrl
// sequencing state machine for one character
// ----------------------------------------------------------------------------
module itr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output itr_pkg::itr_cmd_t cmd,
  input  itr_pkg::itr_stat_t stat
);
  import itr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_OPRD = 4'd2, S_RDB = 4'd3,
    S_RDA = 4'd4, S_WAITA = 4'd5, S_EXEC = 4'd6, S_DIV = 4'd7, S_WR = 4'd8,
    S_SYM = 4'd9, S_FINRD = 4'd10, S_FINWT = 4'd11, S_FIN = 4'd12, S_OUTW = 4'd13,
    S_SETB = 4'd14;

  logic [3:0] state, state_next;
  logic ovalid, ovalid_next;

  assign in_ready = state == S_IDLE;
  assign out_valid = ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      ovalid <= ovalid_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    ovalid_next = ovalid && !out_ready;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (stat.is_letter) begin
          if (stat.val_full) cmd.flag = ST_OVER;
          else cmd.push_val = 1'b1;
          state_next = S_SYM;
        end else if (stat.is_op) begin
          if (stat.op_full) cmd.flag = ST_OVER;
          else cmd.push_op = 1'b1;
          state_next = stat.last ? S_FINRD : S_IDLE;
        end else if (stat.is_close) begin
          if (stat.op_empty) begin
            cmd.flag = ST_UNDER;
            state_next = stat.last ? S_FINRD : S_IDLE;
          end else state_next = S_OPRD;
        end else state_next = stat.last ? S_FINRD : S_IDLE;
      end
      S_OPRD: begin
        cmd.op_read = 1'b1;
        cmd.pop_op = 1'b1;
        if (stat.val_lt2) begin
          cmd.flag = ST_UNDER;
          state_next = S_SYM;
        end else state_next = S_RDB;
      end
      S_RDB: state_next = S_RDA;
      S_RDA: begin
        cmd.val_read = 1'b1;
        cmd.val_read_a = 1'b0;
        state_next = S_WAITA;
      end
      S_WAITA: begin
        cmd.val_read_a = 1'b1;
        state_next = S_SETB;
      end
      S_SETB: begin
        cmd.val_read_a = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.cur_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_WR;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          if (stat.div_zero) cmd.flag = ST_DIVZERO;
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_result = 1'b1;
        state_next = S_SYM;
      end
      S_SYM: if (!ovalid || out_ready) begin
        cmd.set_out_sym = 1'b1;
        ovalid_next = 1'b1;
        state_next = stat.last ? S_FINRD : S_IDLE;
      end
      S_FINRD: state_next = S_FINWT;
      S_FINWT: state_next = S_FIN;
      S_FIN: if (!ovalid || out_ready) begin
        if (stat.val_empty) cmd.flag = ST_UNDER;
        cmd.set_out_fin = 1'b1;
        cmd.clear = 1'b1;
        ovalid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### sv/infix_to_rpn_evaluator.sv
// ----------------------------------------------------------------------------
// infix_to_rpn_evaluator
// fully parenthesized infix to rpn conversion with stack evaluation
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries one character with its operand
// value and a last flag; output channel out_valid/out_ready carries rpn
// symbols and, after the last character, the final value with status.
// one character is taken at a time; a division at a closing parenthesis
// uses the one bit per cycle restoring divider. the output register holds
// a result while the receiver stalls and the sequencer waits before
// overwriting it, with in_ready held low.
// synchronous reset empties both stacks and clears the sticky status;
// stack contents are not cleared.
// ----------------------------------------------------------------------------
module infix_to_rpn_evaluator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] char_code,
  input  logic signed [31:0] operand_value,
  input  logic last,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] rpn_char,
  output logic is_final,
  output logic signed [31:0] result_value,
  output logic [1:0] status
);
  import itr_pkg::*;

  itr_cmd_t cmd;
  itr_stat_t stat;

  itr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  itr_datapath u_dp (
    .clk, .rst, .cmd, .stat, .char_code, .operand_value, .last,
    .rpn_char, .is_final, .result_value, .status
  );
endmodule

### tb/itr_checker.sv
// ----------------------------------------------------------------------------
// itr_checker
// predicts rpn symbols and final values from accepted characters and
// compares every output transfer against the oldest expected result
// ----------------------------------------------------------------------------
module itr_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [7:0] char_code,
  input  logic signed [31:0] operand_value,
  input  logic last,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [7:0] rpn_char,
  input  logic is_final,
  input  logic signed [31:0] result_value,
  input  logic [1:0] status,
  output int fail_count,
  output int pending,
  output int symbol_count,
  output int final_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import itr_pkg::*;

  typedef struct packed {
    logic [7:0] sym;
    logic fin;
    logic [31:0] val;
    logic [1:0] st;
  } eval_result_t;

  eval_result_t want_q[$];
  logic [1:0] op_stk[StackDepth];
  logic [31:0] val_stk[StackDepth];
  int op_sp;
  int val_sp;
  logic [1:0] err_st;

  function automatic logic [1:0] op_code(input logic [7:0] c);
    case (c)
      CH_ADD: return OP_ADD;
      CH_SUB: return OP_SUB;
      CH_MUL: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  function automatic logic [7:0] code_char(input logic [1:0] op);
    case (op)
      OP_ADD: return CH_ADD;
      OP_SUB: return CH_SUB;
      OP_MUL: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  task automatic raise(input logic [1:0] code);
    if (err_st == ST_OK) err_st = code;
  endtask

  task automatic predict_char(input logic [7:0] c, input logic [31:0] v, input logic fin);
    eval_result_t r;
    logic [1:0] op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0] y;
    logic [31:0] ma;
    logic [31:0] mb;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      if (val_sp < StackDepth) begin
        val_stk[val_sp] = v;
        val_sp++;
      end else raise(ST_OVER);
      r = '{sym: c, fin: 1'b0, val: '0, st: err_st};
      want_q.push_back(r);
    end else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV) begin
      if (op_sp < StackDepth) begin
        op_stk[op_sp] = op_code(c);
        op_sp++;
      end else raise(ST_OVER);
    end else if (c == CH_CLOSE) begin
      if (op_sp == 0) raise(ST_UNDER);
      else begin
        op_sp--;
        op = op_stk[op_sp];
        if (val_sp < 2) raise(ST_UNDER);
        else begin
          b = val_stk[val_sp - 1];
          a = val_stk[val_sp - 2];
          case (op)
            OP_ADD: y = a + b;
            OP_SUB: y = a - b;
            OP_MUL: y = a * b;
            default: begin
              if (b == 0) begin
                raise(ST_DIVZERO);
                y = '0;
              end else begin
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                y = ma / mb;
                if (a[31] != b[31]) y = -y;
              end
            end
          endcase
          val_sp--;
          val_stk[val_sp - 1] = y;
        end
        r = '{sym: code_char(op), fin: 1'b0, val: '0, st: err_st};
        want_q.push_back(r);
      end
    end
    if (fin) begin
      y = '0;
      if (val_sp == 0) raise(ST_UNDER);
      else y = val_stk[val_sp - 1];
      r = '{sym: 8'd0, fin: 1'b1, val: y, st: err_st};
      want_q.push_back(r);
      op_sp = 0;
      val_sp = 0;
      err_st = ST_OK;
    end
  endtask

  always @(posedge clk) begin
    eval_result_t w;
    if (rst) begin
      op_sp = 0;
      val_sp = 0;
      err_st = ST_OK;
      fail_count <= 0;
      symbol_count <= 0;
      final_count <= 0;
      want_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected transfer sym=%h fin=%b val=%h st=%0d", $time,
                   rpn_char, is_final, result_value, status);
          fail_count <= fail_count + 1;
        end else begin
          w = want_q.pop_front();
          if (w.sym !== rpn_char || w.fin !== is_final || w.val !== result_value ||
              w.st !== status) begin
            $display("%0t: mismatch expected sym=%h fin=%b val=%h st=%0d", $time,
                     w.sym, w.fin, w.val, w.st);
            $display("%0t:          actual   sym=%h fin=%b val=%h st=%0d", $time,
                     rpn_char, is_final, result_value, status);
            fail_count <= fail_count + 1;
          end
          if (is_final) final_count <= final_count + 1;
          else symbol_count <= symbol_count + 1;
        end
      end
      if (in_valid && in_ready) predict_char(char_code, operand_value, last);
      pending <= want_q.size();
    end
  end
endmodule

### tb/tb_infix_to_rpn_evaluator.sv
// ----------------------------------------------------------------------------
// tb_infix_to_rpn_evaluator
// drives directed and random expressions into the evaluator with bursty
// input and stalling output; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_infix_to_rpn_evaluator;
  timeunit 1ns;
  timeprecision 1ps;
  import itr_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] char_code;
  logic signed [31:0] operand_value;
  logic last;
  logic out_valid;
  logic out_ready;
  logic [7:0] rpn_char;
  logic is_final;
  logic signed [31:0] result_value;
  logic [1:0] status;
  int fail_count;
  int pending;
  int symbol_count;
  int final_count;
  int burst_left;
  bit long_hold;
  int sent;

  infix_to_rpn_evaluator u_top (.*);

  itr_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stall pattern, with one long hold-off on request
  initial begin
    int k;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        for (k = 0; k < 400; k++) @(posedge clk);
        long_hold = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_ready <= 1'b0;
        1: out_ready <= ($urandom_range(0, 4) != 0);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  task automatic send_char(input logic [7:0] c, input logic [31:0] v, input logic l);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) == 0) begin
        g = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    char_code <= c;
    operand_value <= v;
    last <= l;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hffff_ffff;
      2: return 32'd0;
      3: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? 8'd65 : 8'd97) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // well-formed expression: ( e op e ) with random content
  task automatic send_expr(input int depth, input bit close_last);
    logic [7:0] op;
    if (depth == 0 || $urandom_range(0, 2) == 0) begin
      send_char(rand_letter(), rand_value(), close_last);
    end else begin
      op = rand_op();
      send_char("(", $urandom, 1'b0);
      send_expr(depth - 1, 1'b0);
      send_char(op, $urandom, 1'b0);
      send_expr(depth - 1, 1'b0);
      send_char(CH_CLOSE, $urandom, close_last);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int i;
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = '0;
    operand_value = '0;
    last = 1'b0;
    burst_left = 0;
    long_hold = 1'b0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, each operator, overflow wrap, divide by zero
    send_char("a", 32'h8000_0000, 1'b0);
    send_char("/", 0, 1'b0);
    send_char("Z", 32'hffff_ffff, 1'b0);
    send_char(CH_CLOSE, 0, 1'b1);
    send_char("b", 32'h7fff_ffff, 1'b0);
    send_char("+", 0, 1'b0);
    send_char("z", 32'd1, 1'b0);
    send_char(CH_CLOSE, 0, 1'b1);
    send_char("c", 7, 1'b0);
    send_char("/", 0, 1'b0);
    send_char("d", 0, 1'b0);
    send_char(CH_CLOSE, 0, 1'b1);
    send_char("e", -7, 1'b0);
    send_char("-", 0, 1'b0);
    send_char("*", 0, 1'b0);
    send_char("f", 3, 1'b0);
    send_char(CH_CLOSE, 0, 1'b0);
    send_char(CH_CLOSE, 0, 1'b1);
    send_char(CH_CLOSE, 0, 1'b0);
    send_char(8'hff, 32'hffff_ffff, 1'b1);
    send_char(" ", 0, 1'b1);

    // stack overflow on both stacks, then sender waits for drain
    for (i = 0; i < 34; i++) send_char(rand_letter(), rand_value(), 1'b0);
    for (i = 0; i < 34; i++) send_char(rand_op(), 0, 1'b0);
    for (i = 0; i < 36; i++) send_char(CH_CLOSE, 0, i == 35);
    wait_drained();

    // long receiver hold-off while characters keep coming
    long_hold = 1'b1;
    for (i = 0; i < 20; i++) send_expr(3, 1'b1);

    while (sent < 2000) begin
      n = $urandom_range(0, 9);
      if (n < 7) send_expr($urandom_range(1, 4), 1'b1);
      else if (n == 7) send_char(8'($urandom), $urandom, $urandom_range(0, 3) == 0);
      else if (n == 8) send_char(CH_CLOSE, $urandom, 1'($urandom_range(0, 1)));
      else begin
        send_expr(2, 1'b0);
        send_char(rand_op(), 0, 1'b0);
        send_char(rand_letter(), rand_value(), 1'b1);
      end
    end

    wait_drained();
    $display("run covered %0d characters, %0d rpn symbols and %0d final values",
             sent, symbol_count, final_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
